@@ sv/vthd_pkg.sv @@
// ---------------------------------------------------------------------------
// vthd_pkg: vocabulary tree Hamming descent shared definitions
// Tree sizes, field widths and command codes of the descent block.
// ---------------------------------------------------------------------------
package vthd_pkg;

   localparam int MAX_NODES  = 16384;
   localparam int MAX_BRANCH = 16;
   localparam int MAX_DEPTH  = 8;
   localparam int DESC_BITS  = 256;

   localparam int WORD_W     = 64;
   localparam int DESC_WORDS = DESC_BITS / WORD_W;
   localparam int SEL_W      = $clog2(DESC_WORDS);
   localparam int NODE_W     = 14;
   localparam int CHILD_W    = NODE_W + 1;
   localparam int COUNT_W    = 5;
   localparam int NCOUNT_W   = 15;
   localparam int DIST_W     = $clog2(DESC_BITS + 1);
   localparam int POP_W      = $clog2(WORD_W + 1);
   localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
   localparam int META_W     = NODE_W + COUNT_W + NODE_W;

   localparam logic [COUNT_W-1:0] BRANCH_LIMIT = COUNT_W'(MAX_BRANCH);
   localparam logic [CHILD_W-1:0] NODE_LIMIT   = CHILD_W'(MAX_NODES);
   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT  = DEPTH_W'(MAX_DEPTH);
   localparam logic [NODE_W-1:0]  LAST_NODE    = NODE_W'(MAX_NODES - 1);
   localparam logic [SEL_W-1:0]   LAST_SEL     = SEL_W'(DESC_WORDS - 1);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // node record as kept in the metadata memory
   typedef struct packed {
      logic [NODE_W-1:0]  first_child;
      logic [COUNT_W-1:0] child_count;
      logic [NODE_W-1:0]  word;
   } meta_type;

endpackage

@@ sv/vocab_tree_hamming_descent.sv @@
// ---------------------------------------------------------------------------
// vocab_tree_hamming_descent: binary vocabulary tree lookup
// Loads tree nodes into on-chip memory and walks a 256-bit query down the
// tree by smallest Hamming distance, one 64-bit popcount per cycle while a child is scored.
// ---------------------------------------------------------------------------
// After reset the block sweeps the node table to mark every node a leaf: busy
// stays high for the whole sweep and no start is taken (csr writes are). A load
// beat is written while idle and busy never rises for it. A query walks the
// tree: each level reads the node record, then scans its children; a usable
// child gets a descriptor read plus four 64-bit popcount steps on the single
// shared popcount/compare unit, a skipped child gets one scan step, and the
// level ends when the scan passes the last child. The result beat is shown on
// rsp_valid for one cycle and must be taken then; a new start is accepted in
// that same cycle.
module vocab_tree_hamming_descent
   import vthd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [NODE_W-1:0]   req_node_index,
   input  logic [WORD_W-1:0]   req_desc_word0,
   input  logic [WORD_W-1:0]   req_desc_word1,
   input  logic [WORD_W-1:0]   req_desc_word2,
   input  logic [WORD_W-1:0]   req_desc_word3,
   input  logic [NODE_W-1:0]   req_first_child,
   input  logic [COUNT_W-1:0]  req_child_count,
   input  logic [NODE_W-1:0]   req_leaf_word,
   output logic                rsp_valid,
   output logic [NODE_W-1:0]   rsp_leaf_node,
   output logic [NODE_W-1:0]   rsp_word_index,
   output logic                rsp_depth_cut,
   input  logic                csr_we,
   input  logic [NCOUNT_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_META,
      ST_CHILD,
      ST_SCAN,
      ST_POP
   } state_type;

   function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] x);
      logic [1:0] l1 [32];
      logic [2:0] l2 [16];
      logic [3:0] l3 [8];
      logic [4:0] l4 [4];
      logic [5:0] l5 [2];
      for (int i = 0; i < 32; i++) l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
      for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
      for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
      for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
      for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
      return {1'b0, l5[0]} + {1'b0, l5[1]};
   endfunction

   // memories
   logic [DESC_BITS-1:0] desc_mem [MAX_NODES];
   meta_type             meta_mem [MAX_NODES];
   logic [DESC_BITS-1:0] desc_rd_ff;
   meta_type             meta_rd_ff;

   // control and datapath registers
   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    clr_ff, clr_in;
   logic [WORD_W-1:0]    q_ff [DESC_WORDS];
   logic [WORD_W-1:0]    q_in [DESC_WORDS];
   logic [NODE_W-1:0]    cur_ff, cur_in;
   logic [NODE_W-1:0]    best_ff, best_in;
   logic [DIST_W-1:0]    best_d_ff, best_d_in;
   logic                 found_ff, found_in;
   logic [NODE_W-1:0]    fc_ff, fc_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [NODE_W-1:0]    word_ff, word_in;
   logic [COUNT_W-1:0]   k_ff, k_in;
   logic [SEL_W-1:0]     sel_ff, sel_in;
   logic [DIST_W-1:0]    acc_ff, acc_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [NCOUNT_W-1:0]  ncount_ff, ncount_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]    rsp_leaf_ff, rsp_leaf_in;
   logic [NODE_W-1:0]    rsp_word_ff, rsp_word_in;
   logic                 rsp_cut_ff, rsp_cut_in;

   logic                 load_we;
   logic                 meta_we;
   logic [NODE_W-1:0]    meta_waddr;
   meta_type             meta_wdata;
   meta_type             load_meta;
   logic [CHILD_W-1:0]   child_idx;
   logic                 child_ok;
   logic                 desc_re;
   logic [WORD_W-1:0]    desc_slice;
   logic [POP_W-1:0]     pop;
   logic [DIST_W-1:0]    acc_sum;

   assign busy = (state_ff != ST_IDLE);

   assign load_we = (state_ff == ST_IDLE) && start && (req_command == CMD_LOAD);

   always_comb begin
      load_meta.first_child = req_first_child;
      load_meta.child_count = (req_child_count > BRANCH_LIMIT) ? BRANCH_LIMIT
                                                                : req_child_count;
      load_meta.word        = req_leaf_word;
   end

   // the clearing sweep zeroes the whole record; only the child count matters
   assign meta_we    = load_we || (state_ff == ST_CLEAR);
   assign meta_waddr = (state_ff == ST_CLEAR) ? clr_ff : req_node_index;
   assign meta_wdata = (state_ff == ST_CLEAR) ? meta_type'('0) : load_meta;

   assign child_idx  = {1'b0, fc_ff} + CHILD_W'(k_ff);
   assign child_ok   = (child_idx < CHILD_W'(ncount_ff)) && (child_idx < NODE_LIMIT);
   assign desc_re    = (state_ff == ST_SCAN) && (k_ff != cnt_ff) && child_ok;

   assign desc_slice = desc_rd_ff[sel_ff*WORD_W +: WORD_W];
   assign pop        = popcount64(desc_slice ^ q_ff[sel_ff]);
   assign acc_sum    = acc_ff + DIST_W'(pop);

   always_ff @(posedge clock) begin
      if (load_we) begin
         desc_mem[req_node_index] <= {req_desc_word3, req_desc_word2,
                                      req_desc_word1, req_desc_word0};
      end
      if (desc_re) begin
         desc_rd_ff <= desc_mem[child_idx[NODE_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[cur_ff];
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      q_in         = q_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      best_d_in    = best_d_ff;
      found_in     = found_ff;
      fc_in        = fc_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      acc_in       = acc_ff;
      depth_in     = depth_ff;
      ncount_in    = csr_we ? csr_wdata : ncount_ff;
      rsp_valid_in = 1'b0;
      rsp_leaf_in  = rsp_leaf_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_cut_in   = rsp_cut_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + NODE_W'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && (req_command == CMD_QUERY)) begin
               q_in[0]  = req_desc_word0;
               q_in[1]  = req_desc_word1;
               q_in[2]  = req_desc_word2;
               q_in[3]  = req_desc_word3;
               cur_in   = '0;
               depth_in = '0;
               state_in = ST_META;
            end
         end
         ST_META: begin
            // record of cur is read this cycle
            state_in = ST_CHILD;
         end
         ST_CHILD: begin
            fc_in    = meta_rd_ff.first_child;
            cnt_in   = meta_rd_ff.child_count;
            word_in  = meta_rd_ff.word;
            k_in     = '0;
            found_in = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (k_ff == cnt_ff) begin
               if (!found_ff || (depth_ff >= DEPTH_LIMIT)) begin
                  rsp_valid_in = 1'b1;
                  rsp_leaf_in  = cur_ff;
                  rsp_word_in  = word_ff;
                  rsp_cut_in   = found_ff;
                  state_in     = ST_IDLE;
               end else begin
                  cur_in   = best_ff;
                  depth_in = depth_ff + DEPTH_W'(1);
                  state_in = ST_META;
               end
            end else if (child_ok) begin
               acc_in   = '0;
               sel_in   = '0;
               state_in = ST_POP;
            end else begin
               // skip a child outside the tree
               k_in = k_ff + COUNT_W'(1);
            end
         end
         ST_POP: begin
            if (sel_ff == LAST_SEL) begin
               if (!found_ff || (acc_sum < best_d_ff)) begin
                  found_in  = 1'b1;
                  best_d_in = acc_sum;
                  best_in   = child_idx[NODE_W-1:0];
               end
               k_in     = k_ff + COUNT_W'(1);
               state_in = ST_SCAN;
            end else begin
               acc_in = acc_sum;
               sel_in = sel_ff + SEL_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ncount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ncount_ff    <= ncount_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
      q_ff        <= q_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      best_d_ff   <= best_d_in;
      fc_ff       <= fc_in;
      cnt_ff      <= cnt_in;
      word_ff     <= word_in;
      k_ff        <= k_in;
      sel_ff      <= sel_in;
      acc_ff      <= acc_in;
      depth_ff    <= depth_in;
      rsp_leaf_ff <= rsp_leaf_in;
      rsp_word_ff <= rsp_word_in;
      rsp_cut_ff  <= rsp_cut_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_leaf_node  = rsp_leaf_ff;
   assign rsp_word_index = rsp_word_ff;
   assign rsp_depth_cut  = rsp_cut_ff;

endmodule

@@ sim/vthd_walk_checker.sv @@
// ---------------------------------------------------------------------------
// vthd_walk_checker: tree walk predictor and result checker
// Watches node loads, queries and node_count writes on the descent block,
// walks its own copy of the tree for every accepted query and compares each
// result beat with the oldest walk still waiting.
// ---------------------------------------------------------------------------
module vthd_walk_checker
   import vthd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_command,
   input  logic [NODE_W-1:0]   req_node_index,
   input  logic [WORD_W-1:0]   req_desc_word0,
   input  logic [WORD_W-1:0]   req_desc_word1,
   input  logic [WORD_W-1:0]   req_desc_word2,
   input  logic [WORD_W-1:0]   req_desc_word3,
   input  logic [NODE_W-1:0]   req_first_child,
   input  logic [COUNT_W-1:0]  req_child_count,
   input  logic [NODE_W-1:0]   req_leaf_word,
   input  logic                rsp_valid,
   input  logic [NODE_W-1:0]   rsp_leaf_node,
   input  logic [NODE_W-1:0]   rsp_word_index,
   input  logic                rsp_depth_cut,
   input  logic                csr_we,
   input  logic [NCOUNT_W-1:0] csr_wdata,
   output int unsigned         mismatches,
   output int unsigned         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [NODE_W-1:0] leaf_node;
      logic [NODE_W-1:0] word_index;
      logic              depth_cut;
   } walk_result_type;

   bit [DESC_BITS-1:0] node_key    [MAX_NODES];
   bit [NODE_W-1:0]    node_first  [MAX_NODES];
   bit [COUNT_W-1:0]   node_fanout [MAX_NODES];
   bit [NODE_W-1:0]    node_word   [MAX_NODES];
   bit [NCOUNT_W-1:0]  live_nodes;
   walk_result_type    leaves_due [$];

   // Descend from the root, always taking the closest usable child.
   function automatic walk_result_type walk_tree(input bit [DESC_BITS-1:0] probe);
      int unsigned     lvl, k, cur, best, best_ham, ham, child;
      bit              found, done;
      walk_result_type r;
      cur = 0;
      best = 0;
      best_ham = 0;
      done = 1'b0;
      r.depth_cut = 1'b0;
      for (lvl = 0; lvl <= MAX_DEPTH && !done; lvl++) begin
         found = 1'b0;
         for (k = 0; k < node_fanout[cur]; k++) begin
            child = node_first[cur] + k;
            if (child < live_nodes && child < MAX_NODES) begin
               ham = $countones(probe ^ node_key[child]);
               // strict compare: the lower child keeps a tie
               if (!found || ham < best_ham) begin
                  found = 1'b1;
                  best_ham = ham;
                  best = child;
               end
            end
         end
         if (!found) begin
            done = 1'b1;
         end else if (lvl == MAX_DEPTH) begin
            r.depth_cut = 1'b1;
            done = 1'b1;
         end else begin
            cur = best;
         end
      end
      r.leaf_node = NODE_W'(cur);
      r.word_index = node_word[cur];
      return r;
   endfunction

   always @(posedge clock) begin : watch
      walk_result_type want, got;
      if (reset) begin
         live_nodes = '0;
         mismatches = 0;
         leaves_due.delete();
         foreach (node_fanout[i]) node_fanout[i] = '0;
      end else begin
         if (rsp_valid === 1'b1) begin
            got = {rsp_leaf_node, rsp_word_index, rsp_depth_cut};
            if (leaves_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 100)
                  $display("%0t: result beat with no query waiting: node %0d word %0d cut %0b",
                           $time, got.leaf_node, got.word_index, got.depth_cut);
            end else begin
               want = leaves_due.pop_front();
               if (got.leaf_node !== want.leaf_node || got.word_index !== want.word_index ||
                   got.depth_cut !== want.depth_cut) begin
                  mismatches++;
                  if (mismatches <= 100)
                     $display("%0t: expected node %0d word %0d cut %0b, got %0d %0d %0b",
                              $time, want.leaf_node, want.word_index, want.depth_cut,
                              got.leaf_node, got.word_index, got.depth_cut);
               end
            end
         end
         if (csr_we === 1'b1)
            live_nodes = csr_wdata;
         if (start === 1'b1 && busy === 1'b0) begin
            if (req_command == CMD_LOAD) begin
               node_key[req_node_index] = {req_desc_word3, req_desc_word2,
                                           req_desc_word1, req_desc_word0};
               node_first[req_node_index] = req_first_child;
               // clamp oversized fan-out
               node_fanout[req_node_index] = (req_child_count > BRANCH_LIMIT) ?
                                             BRANCH_LIMIT : req_child_count;
               node_word[req_node_index] = req_leaf_word;
            end else begin
               leaves_due.insert(leaves_due.size(),
                                 walk_tree({req_desc_word3, req_desc_word2,
                                            req_desc_word1, req_desc_word0}));
            end
         end
      end
      pending <= leaves_due.size();
   end

endmodule

@@ sim/vocab_tree_hamming_descent_test.sv @@
// ---------------------------------------------------------------------------
// vocab_tree_hamming_descent_test: testbench for the tree descent block
// Loads small vocabulary trees (cycles, skipped and clamped children, nodes
// at both ends of the table) under changing node_count settings and fires
// queries close to the node descriptors so that ties and deep walks occur.
// The walk checker predicts and compares; this module drives and judges.
// ---------------------------------------------------------------------------
module vocab_tree_hamming_descent_test;
   timeunit 1ns;
   timeprecision 1ps;
   import vthd_pkg::*;

   localparam int unsigned ITEM_TARGET = 1550;
   localparam int unsigned CYCLE_LIMIT = 5_000_000;
   localparam int unsigned SETTLE      = 8;
   localparam int unsigned IDLE_PCT    = 7;
   localparam int unsigned PALETTE     = 6;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_command = CMD_LOAD;
   logic [NODE_W-1:0]   req_node_index = '0;
   logic [WORD_W-1:0]   req_desc_word0 = '0;
   logic [WORD_W-1:0]   req_desc_word1 = '0;
   logic [WORD_W-1:0]   req_desc_word2 = '0;
   logic [WORD_W-1:0]   req_desc_word3 = '0;
   logic [NODE_W-1:0]   req_first_child = '0;
   logic [COUNT_W-1:0]  req_child_count = '0;
   logic [NODE_W-1:0]   req_leaf_word = '0;
   logic                rsp_valid;
   logic [NODE_W-1:0]   rsp_leaf_node;
   logic [NODE_W-1:0]   rsp_word_index;
   logic                rsp_depth_cut;
   logic                csr_we = 1'b0;
   logic [NCOUNT_W-1:0] csr_wdata = '0;

   int unsigned        mismatches;
   int unsigned        pending;
   int unsigned        beats = 0;
   int unsigned        cycle_count = 0;
   bit                 written [MAX_NODES];
   bit [DESC_BITS-1:0] palette [PALETTE];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   vocab_tree_hamming_descent uut (
      .clock, .reset, .start, .busy,
      .req_command, .req_node_index,
      .req_desc_word0, .req_desc_word1, .req_desc_word2, .req_desc_word3,
      .req_first_child, .req_child_count, .req_leaf_word,
      .rsp_valid, .rsp_leaf_node, .rsp_word_index, .rsp_depth_cut,
      .csr_we, .csr_wdata
   );

   vthd_walk_checker walk_check (
      .clock, .reset, .start, .busy,
      .req_command, .req_node_index,
      .req_desc_word0, .req_desc_word1, .req_desc_word2, .req_desc_word3,
      .req_first_child, .req_child_count, .req_leaf_word,
      .rsp_valid, .rsp_leaf_node, .rsp_word_index, .rsp_depth_cut,
      .csr_we, .csr_wdata,
      .mismatches, .pending
   );

   function automatic bit [DESC_BITS-1:0] random_desc();
      bit [DESC_BITS-1:0] d;
      for (int i = 0; i < DESC_BITS / 32; i++) d[i*32 +: 32] = $urandom;
      return d;
   endfunction

   function automatic bit [DESC_BITS-1:0] flip_bits(input bit [DESC_BITS-1:0] d,
                                                    input int unsigned n);
      repeat (n) d[$urandom_range(DESC_BITS - 1)] ^= 1'b1;
      return d;
   endfunction

   function automatic bit [DESC_BITS-1:0] make_node_pattern();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 50) return palette[$urandom_range(PALETTE - 1)];
      if (roll < 85) return flip_bits(palette[$urandom_range(PALETTE - 1)], $urandom_range(1, 4));
      return random_desc();
   endfunction

   function automatic bit [DESC_BITS-1:0] make_query_desc();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) return flip_bits(palette[$urandom_range(PALETTE - 1)], $urandom_range(0, 24));
      if (roll < 85) return random_desc();
      if (roll < 92) return '0;
      return '1;
   endfunction

   // True when every child below the end of the table has been loaded.
   function automatic bit children_written(input bit [NODE_W-1:0] fc,
                                           input bit [COUNT_W-1:0] cc);
      int unsigned span, c, k;
      span = (cc > BRANCH_LIMIT) ? MAX_BRANCH : cc;
      for (k = 0; k < span; k++) begin
         c = fc + k;
         if (c < MAX_NODES && !written[c]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void shape_node(input int unsigned low_span, top_span,
                                      output bit [NODE_W-1:0] fc,
                                      output bit [COUNT_W-1:0] cc);
      int unsigned roll, tries;
      roll = $urandom_range(99);
      if (roll < 30)      cc = '0;
      else if (roll < 75) cc = COUNT_W'($urandom_range(1, 4));
      else if (roll < 92) cc = COUNT_W'($urandom_range(5, MAX_BRANCH));
      else                cc = COUNT_W'($urandom_range(MAX_BRANCH + 1, (1 << COUNT_W) - 1));
      tries = 0;
      do begin
         roll = $urandom_range(99);
         if (roll < 65)      fc = NODE_W'($urandom_range(0, low_span - 1));
         else if (roll < 85) fc = NODE_W'($urandom_range(MAX_NODES - top_span, MAX_NODES - 1));
         else                fc = NODE_W'($urandom_range(0, MAX_NODES - 1));
         tries++;
      end while (!children_written(fc, cc) && tries < 8);
      // children of a top-region node run off the table end: always safe
      if (!children_written(fc, cc))
         fc = NODE_W'($urandom_range(MAX_NODES - top_span, MAX_NODES - 1));
   endfunction

   task automatic idle_gaps();
      while (!(beats >= 600 && beats < 900) && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Leave start high on return; the next beat or idle cycle decides.
   task automatic send_beat(input logic cmd, input bit [NODE_W-1:0] idx,
                            input bit [DESC_BITS-1:0] desc, input bit [NODE_W-1:0] fc,
                            input bit [COUNT_W-1:0] cc, input bit [NODE_W-1:0] word);
      idle_gaps();
      req_command     <= cmd;
      req_node_index  <= idx;
      req_desc_word0  <= desc[63:0];
      req_desc_word1  <= desc[127:64];
      req_desc_word2  <= desc[191:128];
      req_desc_word3  <= desc[255:192];
      req_first_child <= fc;
      req_child_count <= cc;
      req_leaf_word   <= word;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      beats++;
   endtask

   task automatic load_node(input bit [NODE_W-1:0] idx, input bit [DESC_BITS-1:0] desc,
                            input bit [NODE_W-1:0] fc, input bit [COUNT_W-1:0] cc,
                            input bit [NODE_W-1:0] word);
      send_beat(CMD_LOAD, idx, desc, fc, cc, word);
      written[idx] = 1'b1;
   endtask

   task automatic query(input bit [DESC_BITS-1:0] desc);
      send_beat(CMD_QUERY, NODE_W'($urandom), desc, NODE_W'($urandom),
                COUNT_W'($urandom), NODE_W'($urandom));
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy !== 1'b0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_node_count(input int unsigned n);
      drain();
      csr_wdata <= NCOUNT_W'(n);
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned        n, low_span, top_span, live, roll;
      bit [NODE_W-1:0]    fc, idx;
      bit [COUNT_W-1:0]   cc;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // root with two equal children; nothing is usable at node_count zero
      set_node_count(0);
      load_node(0, '1, 1, 2, LAST_NODE);
      load_node(1, '0, 0, 0, 1);
      load_node(2, '0, 0, 0, 2);
      query('0);
      set_node_count(MAX_NODES);
      query('0);
      query('1);
      load_node(2, '1, 0, 0, 0);
      query('1);

      // oversized fan-out at the table end, into a self loop: walk is cut
      for (n = MAX_NODES - 4; n < MAX_NODES - 1; n++)
         load_node(NODE_W'(n), '1, NODE_W'($urandom), 0, NODE_W'(n));
      load_node(LAST_NODE, '0, LAST_NODE, 1, 'h2AAA);
      load_node(0, '1, NODE_W'(MAX_NODES - 4), '1, 'h1555);
      query('0);

      // chain of exactly MAX_DEPTH moves, then shorten it with node_count
      for (n = 0; n < MAX_DEPTH; n++)
         load_node(NODE_W'(n), random_desc(), NODE_W'(n + 1), 1, NODE_W'($urandom));
      load_node(NODE_W'(MAX_DEPTH), random_desc(), 0, 0, NODE_W'($urandom));
      query(random_desc());
      set_node_count(5);
      query(random_desc());

      while (beats < ITEM_TARGET) begin
         low_span = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(2, 20);
         top_span = $urandom_range(1, 12);
         roll = $urandom_range(99);
         if (roll < 35)      live = MAX_NODES;
         else if (roll < 65) live = $urandom_range(1, low_span + 2);
         else if (roll < 75) live = 0;
         else if (roll < 85) live = $urandom_range(0, MAX_NODES);
         else                live = MAX_NODES - $urandom_range(0, top_span);
         set_node_count(live);

         foreach (palette[p]) palette[p] = random_desc();
         if ($urandom_range(3) == 0) palette[0] = '0;
         if ($urandom_range(3) == 0) palette[1] = '1;

         // mark the whole set first: queries come only after it is loaded
         for (n = 0; n < low_span; n++) written[n] = 1'b1;
         for (n = MAX_NODES - top_span; n < MAX_NODES; n++) written[n] = 1'b1;
         for (n = 0; n < low_span; n++) begin
            shape_node(low_span, top_span, fc, cc);
            load_node(NODE_W'(n), make_node_pattern(), fc, cc, NODE_W'($urandom));
         end
         for (n = MAX_NODES - top_span; n < MAX_NODES; n++) begin
            shape_node(low_span, top_span, fc, cc);
            load_node(NODE_W'(n), make_node_pattern(), fc, cc, NODE_W'($urandom));
         end

         repeat ($urandom_range(8, 30)) begin
            if ($urandom_range(99) < 15) begin
               if ($urandom_range(1) == 1) begin
                  idx = ($urandom_range(99) < 70) ?
                        NODE_W'($urandom_range(0, low_span - 1)) :
                        NODE_W'($urandom_range(MAX_NODES - top_span, MAX_NODES - 1));
                  shape_node(low_span, top_span, fc, cc);
                  load_node(idx, make_node_pattern(), fc, cc, NODE_W'($urandom));
               end else begin
                  // stray leaf anywhere in the table
                  load_node(NODE_W'($urandom), random_desc(), NODE_W'($urandom), '0,
                            NODE_W'($urandom));
               end
            end
            query(make_query_desc());
         end
      end

      drain();
      if (mismatches == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
sv/vthd_pkg.sv
sv/vocab_tree_hamming_descent.sv
sim/vthd_walk_checker.sv
sim/vocab_tree_hamming_descent_test.sv
